>>> hw/rtl/pbse_pkg.sv
// ----------------------------------------------------------------------------
// pbse_pkg
// Shared types and codes of the protobuf scalar field encoder.
// ----------------------------------------------------------------------------
package pbse_pkg;

  localparam logic [3:0] CMD_INT32   = 4'd0;
  localparam logic [3:0] CMD_UINT32  = 4'd1;
  localparam logic [3:0] CMD_SINT32  = 4'd2;
  localparam logic [3:0] CMD_INT64   = 4'd3;
  localparam logic [3:0] CMD_UINT64  = 4'd4;
  localparam logic [3:0] CMD_SINT64  = 4'd5;
  localparam logic [3:0] CMD_BOOL    = 4'd6;
  localparam logic [3:0] CMD_ENUM    = 4'd7;
  localparam logic [3:0] CMD_FIXED32 = 4'd8;
  localparam logic [3:0] CMD_FIXED64 = 4'd9;
  localparam logic [3:0] CMD_FLOAT   = 4'd10;
  localparam logic [3:0] CMD_DOUBLE  = 4'd11;

  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  localparam int TAG_W   = 35;
  localparam int QDEPTH  = 2;
  localparam int QAW     = 1;
  localparam int QCNT_W  = 2;

  localparam logic [3:0] LE_BYTES_32 = 4'd4;
  localparam logic [3:0] LE_BYTES_64 = 4'd8;

  typedef struct packed {
    logic              with_tag;
    logic [TAG_W-1:0]  tag;
    logic [63:0]       val;
    logic              le;
    logic [3:0]        cnt;
  } job_t;

endpackage

>>> hw/rtl/protobuf_scalar_field_encoder.sv
// ----------------------------------------------------------------------------
// protobuf_scalar_field_encoder
// Encodes one scalar protobuf field per item into wire-format bytes.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | push / full        | cmd, field_number, value, with_tag,
//           |                    | skip_default, enum_default
//  result   | pop / empty        | out_byte, last
//
//  One output byte per cycle while results are popped; an item gives 1 to 15
//  bytes in the serialiser (tag varint up to 5 bytes, value up to 10).
//  Dropped items (skipped defaults, unused codes) never reach the serialiser.
//  A two-entry job queue parts classifier and serialiser; the output register
//  keeps streaming while results are popped every cycle.
//  rst is synchronous and clears queue, serialiser and output valid flag.
// ----------------------------------------------------------------------------
module protobuf_scalar_field_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         cmd,
  input  logic [31:0]        field_number,
  input  logic [63:0]        value,
  input  logic               with_tag,
  input  logic               skip_default,
  input  logic signed [31:0] enum_default,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte,
  output logic               last
);

  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  pbse_pkg::job_t q_wr_data;
  pbse_pkg::job_t q_rd_data;
  logic           ob_valid;

  pbse_front u_front (
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .field_number (field_number),
    .value        (value),
    .with_tag     (with_tag),
    .skip_default (skip_default),
    .enum_default (enum_default),
    .q_push       (q_push),
    .q_data       (q_wr_data)
  );

  pbse_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .full    (full),
    .empty   (q_empty)
  );

  pbse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .ob_valid (ob_valid),
    .ob_byte  (out_byte),
    .ob_last  (last)
  );

  assign empty = !ob_valid;

endmodule

>>> hw/rtl/pbse_front.sv
// ----------------------------------------------------------------------------
// pbse_front
// Classifies a field: drops skipped defaults and unknown codes, builds tag and value word.
// ----------------------------------------------------------------------------
module pbse_front (
  input  logic               push,
  input  logic               full,
  input  logic [3:0]         cmd,
  input  logic [31:0]        field_number,
  input  logic [63:0]        value,
  input  logic               with_tag,
  input  logic               skip_default,
  input  logic signed [31:0] enum_default,
  output logic               q_push,
  output pbse_pkg::job_t     q_data
);

  logic [31:0] lo;
  logic [2:0]  wire_type;
  logic        is_default;
  logic        known;

  assign lo = value[31:0];

  always_comb begin
    wire_type       = pbse_pkg::WIRE_VARINT;
    is_default      = (value == 64'd0);
    known           = 1'b1;
    q_data.with_tag = with_tag;
    q_data.le       = 1'b0;
    q_data.cnt      = pbse_pkg::LE_BYTES_64;
    q_data.val      = value;
    unique case (cmd)
      pbse_pkg::CMD_INT32, pbse_pkg::CMD_ENUM: begin
        q_data.val = {{32{lo[31]}}, lo};
        is_default = (cmd == pbse_pkg::CMD_ENUM) ? (lo == enum_default) : (lo == 32'd0);
      end
      pbse_pkg::CMD_UINT32: begin
        q_data.val = {32'd0, lo};
        is_default = (lo == 32'd0);
      end
      pbse_pkg::CMD_SINT32: begin
        q_data.val = {32'd0, {lo[30:0], 1'b0} ^ {32{lo[31]}}};
        is_default = (lo == 32'd0);
      end
      pbse_pkg::CMD_INT64, pbse_pkg::CMD_UINT64: begin
        q_data.val = value;
      end
      pbse_pkg::CMD_SINT64: begin
        q_data.val = {value[62:0], 1'b0} ^ {64{value[63]}};
      end
      pbse_pkg::CMD_BOOL: begin
        q_data.val = {63'd0, (value != 64'd0)};
      end
      pbse_pkg::CMD_FIXED32, pbse_pkg::CMD_FLOAT: begin
        wire_type  = pbse_pkg::WIRE_FIXED32;
        q_data.val = {32'd0, lo};
        q_data.le  = 1'b1;
        q_data.cnt = pbse_pkg::LE_BYTES_32;
        is_default = (cmd == pbse_pkg::CMD_FLOAT) ? (lo[30:0] == 31'd0) : (lo == 32'd0);
      end
      pbse_pkg::CMD_FIXED64, pbse_pkg::CMD_DOUBLE: begin
        wire_type  = pbse_pkg::WIRE_FIXED64;
        q_data.le  = 1'b1;
        is_default = (cmd == pbse_pkg::CMD_DOUBLE) ? (value[62:0] == 63'd0)
                                                   : (value == 64'd0);
      end
      default: begin
        known = 1'b0;
      end
    endcase
    q_data.tag = {field_number, wire_type};
  end

  assign q_push = push && !full && known && !(skip_default && is_default);

endmodule

>>> hw/rtl/pbse_fifo.sv
// ----------------------------------------------------------------------------
// pbse_fifo
// Short job queue between the classifier and the byte serialiser.
// ----------------------------------------------------------------------------
module pbse_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  pbse_pkg::job_t wr_data,
  input  logic           rd,
  output pbse_pkg::job_t rd_data,
  output logic           full,
  output logic           empty
);

  pbse_pkg::job_t                  mem [pbse_pkg::QDEPTH];
  logic [pbse_pkg::QAW-1:0]        wr_ptr;
  logic [pbse_pkg::QAW-1:0]        rd_ptr;
  logic [pbse_pkg::QCNT_W-1:0]     count;
  logic                            do_wr;
  logic                            do_rd;

  function automatic logic [pbse_pkg::QCNT_W-1:0] QCNT_INC(input logic b);
    QCNT_INC = {{(pbse_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign full    = (count == pbse_pkg::QCNT_W'(pbse_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_INC(do_wr) - QCNT_INC(do_rd);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pbse_pkg::QCNT_W'(pbse_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_no_lost_write: assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("job written into a full queue");

endmodule

>>> hw/rtl/pbse_back.sv
// ----------------------------------------------------------------------------
// pbse_back
// Serialises one job a byte a cycle while the output advances: tag varint, then value bytes.
// ----------------------------------------------------------------------------
module pbse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  pbse_pkg::job_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           ob_valid,
  output logic [7:0]     ob_byte,
  output logic           ob_last
);

  logic                        active;
  logic                        in_tag;
  logic                        le;
  logic [pbse_pkg::TAG_W-1:0]  tag;
  logic [63:0]                 val;
  logic [3:0]                  cnt;

  logic       adv;
  logic       tag_more;
  logic       val_more;
  logic [7:0] byte_next;
  logic       last_next;
  logic       fin;
  logic       load;

  assign adv      = !ob_valid || pop;
  assign tag_more = |tag[pbse_pkg::TAG_W-1:7];
  assign val_more = |val[63:7];

  always_comb begin
    if (in_tag) begin
      byte_next = {tag_more, tag[6:0]};
      last_next = 1'b0;
    end else if (le) begin
      byte_next = val[7:0];
      last_next = (cnt == 4'd1);
    end else begin
      byte_next = {val_more, val[6:0]};
      last_next = !val_more;
    end
  end

  assign fin   = active && adv && last_next;
  assign load  = !active || fin;
  assign q_pop = load && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      in_tag   <= 1'b0;
      ob_valid <= 1'b0;
    end else begin
      if (adv) begin
        ob_valid <= active;
      end
      if (q_pop) begin
        active <= 1'b1;
        in_tag <= q_data.with_tag;
      end else if (fin) begin
        active <= 1'b0;
        in_tag <= 1'b0;
      end else if (active && adv && in_tag && !tag_more) begin
        in_tag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob_byte <= byte_next;
      ob_last <= last_next;
    end
    if (q_pop) begin
      tag <= q_data.tag;
      val <= q_data.val;
      le  <= q_data.le;
      cnt <= q_data.cnt;
    end else if (active && adv) begin
      if (in_tag) begin
        tag <= tag >> 7;
      end else if (le) begin
        val <= val >> 8;
        cnt <= cnt - 4'd1;
      end else begin
        val <= val >> 7;
      end
    end
  end

  a_le_count: assert property (@(posedge clk) disable iff (rst)
    (active && le && !in_tag) |-> (cnt != 4'd0 && cnt <= pbse_pkg::LE_BYTES_64))
    else $error("little-endian byte count out of range");

  a_tag_in_job: assert property (@(posedge clk) disable iff (rst)
    in_tag |-> active)
    else $error("tag phase without a job");

  a_load_on_finish: assert property (@(posedge clk) disable iff (rst)
    (active && q_pop) |-> (adv && last_next))
    else $error("job replaced before its last byte");

endmodule
